// ----- sv/hgo_pkg.sv -----
`timescale 1ns / 1ps
package hgo_pkg;

    localparam int GRID_ROWS_DEF  = 1024;
    localparam int GRID_COLS_DEF  = 1024;
    localparam int COORD_BITS_DEF = 24;

    localparam int VOX_W      = 10;  // voxel size register
    localparam int DIM_W      = 11;  // rows or columns in use
    localparam int HIT_W      = 8;   // per-frame hit count
    localparam int IDX_OUT_W  = 10;  // reported row and column
    localparam int CFG_IDX_W  = 3;
    localparam int EPOCH_BITS = 8;

    localparam logic [HIT_W-1:0]      HIT_MAX   = '1;
    localparam logic [EPOCH_BITS-1:0] EPOCH_MAX = '1;

    localparam logic [VOX_W-1:0] VOX_RST     = 10'd100;
    localparam logic [HIT_W-1:0] MIN_PTS_RST = 8'd5;
    localparam logic [DIM_W-1:0] DIM_RST     = 11'd1000;
    localparam int               ORIGIN_RST  = -50000;
    localparam int               MOH_RST     = 100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VOXEL_SIZE   = 3'd0,
        CFG_ORIGIN_X     = 3'd1,
        CFG_ORIGIN_Y     = 3'd2,
        CFG_MIN_OBST_H   = 3'd3,
        CFG_MIN_POINTS   = 3'd4,
        CFG_ROWS_IN_USE  = 3'd5,
        CFG_COLS_IN_USE  = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic load;
        logic prep;
        logic clr_en;
        logic clr_map;
        logic check;
        logic div_step;
        logic addr_en;
        logic rd_en;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic wrap;
        logic clr_last;
    } t_sts;

endpackage

// ----- sv/hgo_div_lane.sv -----
`timescale 1ns / 1ps
module hgo_div_lane import hgo_pkg::*; #(
    parameter int NUM_W  = COORD_BITS_DEF + 1,
    parameter int PROD_W = VOX_W + DIM_W,
    parameter int Q_BITS = 10
) (
    input  logic                    i_clk,
    input  logic                    i_check,
    input  logic                    i_step,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic [PROD_W-1:0]       i_lim,
    input  logic [VOX_W-1:0]        i_vox,
    output logic                    o_in_range,
    output logic [Q_BITS-1:0]       o_quot
);

    localparam int CMP_W = (NUM_W - 1 > PROD_W) ? NUM_W - 1 : PROD_W;
    localparam int EXT_W = NUM_W - 1 + VOX_W;

    logic              neg;
    logic [NUM_W-2:0]  mag;
    logic [EXT_W-1:0]  mag_ext;
    logic [NUM_W:0]    neg_sum;
    logic              neg_ok;
    logic              pos_ok;
    logic [VOX_W:0]    trial;
    logic [VOX_W:0]    diff;
    logic              ge;

    logic              r_in_range;
    logic [VOX_W-1:0]  r_part;
    logic [Q_BITS-1:0] r_low;
    logic [Q_BITS-1:0] r_quot;

    assign neg     = i_num[NUM_W-1];
    assign mag     = i_num[NUM_W-2:0];
    assign mag_ext = EXT_W'(mag);

    // A small negative offset truncates to index zero.
    assign neg_sum = {i_num[NUM_W-1], i_num} + (NUM_W+1)'(i_vox);
    assign neg_ok  = !neg_sum[NUM_W] && (neg_sum != '0) && (i_lim != '0);
    // The quotient stays below the limit exactly when the offset is below vox * limit.
    assign pos_ok  = CMP_W'(mag) < CMP_W'(i_lim);

    assign trial = {r_part, r_low[Q_BITS-1]};
    assign diff  = trial - {1'b0, i_vox};
    assign ge    = trial >= {1'b0, i_vox};

    always_ff @(posedge i_clk) begin
        if (i_check) begin
            r_in_range <= neg ? neg_ok : pos_ok;
            r_part     <= neg ? '0 : mag_ext[Q_BITS +: VOX_W];
            r_low      <= neg ? '0 : mag[Q_BITS-1:0];
            r_quot     <= '0;
        end else if (i_step) begin
            r_part <= ge ? diff[VOX_W-1:0] : trial[VOX_W-1:0];
            r_low  <= {r_low[Q_BITS-2:0], 1'b0};
            r_quot <= {r_quot[Q_BITS-2:0], ge};
        end
    end

    assign o_in_range = r_in_range;
    assign o_quot     = r_quot;

endmodule

// ----- sv/hgo_ctrl.sv -----
`timescale 1ns / 1ps
module hgo_ctrl import hgo_pkg::*; #(
    parameter int Q_BITS = 10
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam int STEP_W = $clog2(Q_BITS);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(Q_BITS - 1);

    typedef enum logic [3:0] {
        S_CLR_ALL,
        S_IDLE,
        S_PREP,
        S_CLR_FRM,
        S_CHECK,
        S_DIV,
        S_ADDR,
        S_READ,
        S_UPD
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;
    logic              out_free;
    t_cmd              cmd;

    assign out_free = !r_out_valid || i_m_tready;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        cmd     = '0;
        case (r_state)
            S_CLR_ALL: begin
                cmd.clr_en  = 1'b1;
                cmd.clr_map = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    cmd.load = 1'b1;
                    n_state  = S_PREP;
                end
            end
            S_PREP: begin
                cmd.prep = 1'b1;
                n_state  = i_sts.wrap ? S_CLR_FRM : S_CHECK;
            end
            S_CLR_FRM: begin
                cmd.clr_en = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                cmd.check = 1'b1;
                n_step    = '0;
                n_state   = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (r_step == STEP_LAST) begin
                    n_state = S_ADDR;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_ADDR: begin
                cmd.addr_en = 1'b1;
                n_state     = S_READ;
            end
            S_READ: begin
                cmd.rd_en = 1'b1;
                n_state   = S_UPD;
            end
            S_UPD: begin
                // Hold the cell write until the result register can take the item.
                if (out_free) begin
                    cmd.emit = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = cmd.emit ? 1'b1 : (i_m_tready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR_ALL;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_cmd      = cmd;

endmodule

// ----- sv/hgo_datapath.sv -----
`timescale 1ns / 1ps
module hgo_datapath import hgo_pkg::*; #(
    parameter int GRID_ROWS  = GRID_ROWS_DEF,
    parameter int GRID_COLS  = GRID_COLS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int Q_BITS     = 10
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cmd                         i_cmd,
    output t_sts                         o_sts,
    input  logic                         i_frame_start,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    input  logic signed [COORD_BITS-1:0] i_point_z,
    input  logic [VOX_W-1:0]             i_vox,
    input  logic signed [COORD_BITS-1:0] i_origin_x,
    input  logic signed [COORD_BITS-1:0] i_origin_y,
    input  logic signed [COORD_BITS-1:0] i_min_obst_h,
    input  logic [HIT_W-1:0]             i_min_points,
    input  logic [DIM_W-1:0]             i_rows,
    input  logic [DIM_W-1:0]             i_cols,
    output logic                         o_in_grid,
    output logic [IDX_OUT_W-1:0]         o_cell_row,
    output logic [IDX_OUT_W-1:0]         o_cell_col,
    output logic                         o_map_updated,
    output logic signed [COORD_BITS-1:0] o_cell_height,
    output logic                         o_occupied
);

    localparam int CELLS     = GRID_ROWS * GRID_COLS;
    localparam int ADDR_BITS = $clog2(CELLS);
    localparam int NUM_W     = COORD_BITS + 1;
    localparam int PROD_W    = VOX_W + DIM_W;
    localparam int FRM_W     = EPOCH_BITS + HIT_W + COORD_BITS;
    localparam int MAP_W     = COORD_BITS + 2;

    logic signed [COORD_BITS-1:0] r_px, r_py, r_pz;
    logic [EPOCH_BITS-1:0]        r_epoch;
    logic                         r_wrap;
    logic [ADDR_BITS-1:0]         r_clr_addr;
    logic signed [NUM_W-1:0]      r_num_r, r_num_c;
    logic [PROD_W-1:0]            r_prod_r, r_prod_c;
    logic [ADDR_BITS-1:0]         r_addr;
    logic                         r_in_grid;
    logic [FRM_W-1:0]             r_frd;
    logic [MAP_W-1:0]             r_mrd;

    // Frame store: epoch tag, hit count, frame maximum height.
    logic [FRM_W-1:0] r_frm_mem [CELLS];
    // Map store: known flag, map height, occupancy.
    logic [MAP_W-1:0] r_map_mem [CELLS];

    logic [VOX_W-1:0]             vox_eff;
    logic [DIM_W-1:0]             rmax, cmax;
    logic                         in_r, in_c;
    logic [Q_BITS-1:0]            q_r, q_c;
    logic                         clr_last;

    logic [EPOCH_BITS-1:0]        tag;
    logic [HIT_W-1:0]             cnt;
    logic signed [COORD_BITS-1:0] fmax;
    logic [HIT_W-1:0]             old;
    logic [HIT_W:0]               old_inc;
    logic                         raise, reached, past, upd;
    logic [HIT_W-1:0]             new_cnt;
    logic signed [COORD_BITS-1:0] fmax_new;
    logic                         occ_new;

    logic                         frm_we, map_we;
    logic [ADDR_BITS-1:0]         wr_addr;
    logic [FRM_W-1:0]             frm_wd;
    logic [MAP_W-1:0]             map_wd;

    assign vox_eff  = (i_vox == '0) ? VOX_W'(1) : i_vox;
    assign rmax     = (int'(i_rows) < GRID_ROWS) ? i_rows : DIM_W'(GRID_ROWS);
    assign cmax     = (int'(i_cols) < GRID_COLS) ? i_cols : DIM_W'(GRID_COLS);
    assign clr_last = (r_clr_addr == ADDR_BITS'(CELLS - 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px <= i_point_x;
            r_py <= i_point_y;
            r_pz <= i_point_z;
        end
        if (i_cmd.prep) begin
            r_num_r  <= {r_py[COORD_BITS-1], r_py} - {i_origin_y[COORD_BITS-1], i_origin_y};
            r_num_c  <= {r_px[COORD_BITS-1], r_px} - {i_origin_x[COORD_BITS-1], i_origin_x};
            r_prod_r <= PROD_W'(vox_eff) * PROD_W'(rmax);
            r_prod_c <= PROD_W'(vox_eff) * PROD_W'(cmax);
        end
        if (i_cmd.addr_en) begin
            r_in_grid <= in_r && in_c;
            r_addr    <= (in_r && in_c) ?
                         ADDR_BITS'(int'(q_r) * GRID_COLS + int'(q_c)) : '0;
        end
    end

    // A frame start moves to a new epoch, so older hit counts read as zero.
    // When the tag space runs out, every tag is swept back to zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epoch    <= EPOCH_BITS'(1);
            r_wrap     <= 1'b0;
            r_clr_addr <= '0;
        end else begin
            if (i_cmd.load && i_frame_start) begin
                if (r_epoch == EPOCH_MAX) begin
                    r_epoch <= EPOCH_BITS'(1);
                    r_wrap  <= 1'b1;
                end else begin
                    r_epoch <= r_epoch + 1'b1;
                end
            end else if (i_cmd.clr_en) begin
                r_wrap <= 1'b0;
            end
            if (i_cmd.clr_en) begin
                r_clr_addr <= clr_last ? '0 : r_clr_addr + 1'b1;
            end
        end
    end

    hgo_div_lane #(
        .NUM_W  (NUM_W),
        .PROD_W (PROD_W),
        .Q_BITS (Q_BITS)
    ) u_row_lane (
        .i_clk      (i_clk),
        .i_check    (i_cmd.check),
        .i_step     (i_cmd.div_step),
        .i_num      (r_num_r),
        .i_lim      (r_prod_r),
        .i_vox      (vox_eff),
        .o_in_range (in_r),
        .o_quot     (q_r)
    );

    hgo_div_lane #(
        .NUM_W  (NUM_W),
        .PROD_W (PROD_W),
        .Q_BITS (Q_BITS)
    ) u_col_lane (
        .i_clk      (i_clk),
        .i_check    (i_cmd.check),
        .i_step     (i_cmd.div_step),
        .i_num      (r_num_c),
        .i_lim      (r_prod_c),
        .i_vox      (vox_eff),
        .o_in_range (in_c),
        .o_quot     (q_c)
    );

    assign tag  = r_frd[FRM_W-1 -: EPOCH_BITS];
    assign cnt  = r_frd[COORD_BITS +: HIT_W];
    assign fmax = r_frd[COORD_BITS-1:0];

    assign old      = (tag == r_epoch) ? cnt : '0;
    assign old_inc  = {1'b0, old} + 1'b1;
    assign raise    = (old == '0) || (fmax < r_pz);
    assign reached  = (old != HIT_MAX) && (old_inc == {1'b0, i_min_points});
    assign past     = old >= i_min_points;
    assign upd      = reached || (past && raise);
    assign new_cnt  = (old != HIT_MAX) ? old_inc[HIT_W-1:0] : old;
    assign fmax_new = raise ? r_pz : fmax;
    assign occ_new  = upd ? (fmax_new >= i_min_obst_h) : r_mrd[0];

    assign wr_addr = i_cmd.clr_en ? r_clr_addr : r_addr;
    assign frm_we  = i_cmd.clr_en || (i_cmd.emit && r_in_grid);
    assign map_we  = (i_cmd.clr_en && i_cmd.clr_map) || (i_cmd.emit && r_in_grid && upd);
    assign frm_wd  = i_cmd.clr_en ? '0 : {r_epoch, new_cnt, fmax_new};
    assign map_wd  = i_cmd.clr_en ? '0 : {1'b1, fmax_new, occ_new};

    always_ff @(posedge i_clk) begin
        if (frm_we) begin
            r_frm_mem[wr_addr] <= frm_wd;
        end
        if (i_cmd.rd_en) begin
            r_frd <= r_frm_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_map_mem[wr_addr] <= map_wd;
        end
        if (i_cmd.rd_en) begin
            r_mrd <= r_map_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_in_grid     <= r_in_grid;
            o_cell_row    <= r_in_grid ? IDX_OUT_W'(q_r) : '0;
            o_cell_col    <= r_in_grid ? IDX_OUT_W'(q_c) : '0;
            o_map_updated <= r_in_grid && upd;
            o_cell_height <= r_in_grid ? fmax_new : '0;
            o_occupied    <= r_in_grid && occ_new;
        end
    end

    assign o_sts.wrap     = r_wrap;
    assign o_sts.clr_last = clr_last;

endmodule

// ----- sv/height_grid_occupancy_update.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Handshake                 Payload
// s         in         i_s_tvalid / o_s_tready   tdata: point_x, point_y, point_z;
//                                                tuser: frame_start
// m         out        o_m_tvalid / i_m_tready   tdata: cell_row, cell_col, map_updated,
//                                                cell_height, occupied; tuser: in_grid
// cfg       in         i_cfg_we                  i_cfg_idx, i_cfg_data
//
// From acceptance to the next acceptance, an item runs the one-bit-per-cycle quotient loop
// of the row and column divide lanes, followed by one cell read and one cell write.
// After reset the block clears both cell stores before its first item; every 255th frame
// start adds a sweep over every cell of the frame store.
// One item may be taken while an earlier result still waits; its result is then held in
// the update state, with no input taken, until the result register frees.
module height_grid_occupancy_update import hgo_pkg::*; #(
    parameter int GRID_ROWS  = GRID_ROWS_DEF,
    parameter int GRID_COLS  = GRID_COLS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_s_tvalid,
    output logic                                       o_s_tready,
    // point_x, point_y, point_z
    input  logic [((3*COORD_BITS+7)/8)*8-1:0]          i_s_tdata,
    // frame_start
    input  logic                                       i_s_tuser,
    output logic                                       o_m_tvalid,
    input  logic                                       i_m_tready,
    // cell_row, cell_col, map_updated, cell_height, occupied
    output logic [((2*IDX_OUT_W+2+COORD_BITS+7)/8)*8-1:0] o_m_tdata,
    // in_grid
    output logic                                       o_m_tuser,
    input  logic                                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]                       i_cfg_idx,
    input  logic [COORD_BITS-1:0]                      i_cfg_data
);

    localparam int Q_ROW  = $clog2(GRID_ROWS);
    localparam int Q_COL  = $clog2(GRID_COLS);
    localparam int Q_BITS = (Q_ROW > Q_COL) ? Q_ROW : Q_COL;
    localparam int OUT_W  = ((2*IDX_OUT_W+2+COORD_BITS+7)/8)*8;
    localparam int UPD_BIT = 2 * IDX_OUT_W;

    logic [VOX_W-1:0]             r_vox;
    logic signed [COORD_BITS-1:0] r_origin_x, r_origin_y, r_min_obst_h;
    logic [HIT_W-1:0]             r_min_points;
    logic [DIM_W-1:0]             r_rows, r_cols;

    t_cmd                         cmd;
    t_sts                         sts;
    logic                         in_grid;
    logic [IDX_OUT_W-1:0]         cell_row, cell_col;
    logic                         map_updated;
    logic signed [COORD_BITS-1:0] cell_height;
    logic                         occupied;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vox        <= VOX_RST;
            r_origin_x   <= COORD_BITS'(ORIGIN_RST);
            r_origin_y   <= COORD_BITS'(ORIGIN_RST);
            r_min_obst_h <= COORD_BITS'(MOH_RST);
            r_min_points <= MIN_PTS_RST;
            r_rows       <= DIM_RST;
            r_cols       <= DIM_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_VOXEL_SIZE:  r_vox        <= i_cfg_data[VOX_W-1:0];
                CFG_ORIGIN_X:    r_origin_x   <= i_cfg_data;
                CFG_ORIGIN_Y:    r_origin_y   <= i_cfg_data;
                CFG_MIN_OBST_H:  r_min_obst_h <= i_cfg_data;
                CFG_MIN_POINTS:  r_min_points <= i_cfg_data[HIT_W-1:0];
                CFG_ROWS_IN_USE: r_rows       <= i_cfg_data[DIM_W-1:0];
                CFG_COLS_IN_USE: r_cols       <= i_cfg_data[DIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    hgo_ctrl #(
        .Q_BITS (Q_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    hgo_datapath #(
        .GRID_ROWS  (GRID_ROWS),
        .GRID_COLS  (GRID_COLS),
        .COORD_BITS (COORD_BITS),
        .Q_BITS     (Q_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_frame_start (i_s_tuser),
        .i_point_x     (i_s_tdata[COORD_BITS-1:0]),
        .i_point_y     (i_s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .i_point_z     (i_s_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .i_vox         (r_vox),
        .i_origin_x    (r_origin_x),
        .i_origin_y    (r_origin_y),
        .i_min_obst_h  (r_min_obst_h),
        .i_min_points  (r_min_points),
        .i_rows        (r_rows),
        .i_cols        (r_cols),
        .o_in_grid     (in_grid),
        .o_cell_row    (cell_row),
        .o_cell_col    (cell_col),
        .o_map_updated (map_updated),
        .o_cell_height (cell_height),
        .o_occupied    (occupied)
    );

    assign o_m_tdata = OUT_W'({occupied, cell_height, map_updated, cell_col, cell_row});
    assign o_m_tuser = in_grid;

    // Only one item is in work at a time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input taken while an item is in work");

    // A point outside the grid reports all-zero payload.
    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == '0))
        else $error("outside point with nonzero payload");

    // A map update is only reported for a cell inside the grid.
    a_upd_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[UPD_BIT]) |-> o_m_tuser)
        else $error("map update outside the grid");

    // A new result appears together with the return to the idle state.
    a_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> o_s_tready)
        else $error("result issued while still busy");

endmodule
